FILE: rtl/core/tqsb_pkg.sv
// package for the two-queue shared buffer block
// request, command and response types, function and status codes
// no dependencies
`timescale 1ns / 1ps

package tqsb_pkg;

   localparam int VALUE_W     = 32;
   localparam int MAX_RESULTS = 16;
   localparam int COUNT_W     = $clog2(MAX_RESULTS);
   localparam int CMD_DEPTH   = 2;
   localparam int RSP_DEPTH   = 2;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_DEL  = 2'd1;
   localparam logic [1:0] FUNC_LIST = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OVF   = 2'd1;
   localparam logic [1:0] STAT_UNDER = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_DEL,
      OP_LIST
   } op_type;

   typedef struct packed {
      logic [1:0]                func;
      logic                      queue_sel;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      op_type                    op;
      logic                      queue_sel;
      logic signed [VALUE_W-1:0] item_value;
   } cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [1:0]                status;
      logic                      which_queue;
      logic                      last;
   } rsp_type;

endpackage

FILE: rtl/core/two_queues_shared_buffer.sv
// top level of the two-queue shared buffer block
// depends on tqsb_pkg, tqsb_front, tqsb_back and tqsb_fifo
//
// Two queues share one store of CAPACITY words: queue one grows up from the
// bottom entry, queue two grows down from the top entry. A request selects a
// queue and asks to add a value, delete the head, or list the contents.
// Requests enter on req_push/req_full; unknown function codes are taken and
// dropped. Responses leave on rsp_empty/rsp_pop, oldest first; a list gives
// one response per element from head to tail (at most 16) with last set on
// the final one, every other known request gives exactly one response.
// An add, or any request on an empty queue, is answered straight from the
// command; a delete or a list element goes through the store's registered read.
// The back end's sequencer takes a new add every clock while the response
// queue has room; as the store has one registered read port, a delete or list
// holds it until its last response. A two-entry command queue and a two-entry
// response queue decouple the sides; a stalled receiver backs up into req_full.
// Reset empties both queues; store contents are undefined until written.
`timescale 1ns / 1ps

module two_queues_shared_buffer #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  tqsb_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output tqsb_pkg::rsp_type rsp_data,
   output logic              rsp_empty
);

   tqsb_pkg::cmd_type cmd_data;
   logic              cmd_empty;
   logic              cmd_pop;
   tqsb_pkg::rsp_type rsp_item;
   logic              rsp_push;
   logic              rsp_full;
   logic [$bits(tqsb_pkg::rsp_type)-1:0] rsp_vec;

   tqsb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty)
   );

   tqsb_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_item  (rsp_item),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   tqsb_fifo #(
      .WIDTH ($bits(tqsb_pkg::rsp_type)),
      .DEPTH (tqsb_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (rsp_item),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .data_out (rsp_vec),
      .empty    (rsp_empty)
   );

   assign rsp_data = tqsb_pkg::rsp_type'(rsp_vec);

endmodule

FILE: rtl/core/tqsb_fifo.sv
// small register queue used between the block's parts
// generic width and depth, no package dependency
`timescale 1ns / 1ps

module tqsb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: rtl/core/tqsb_front.sv
// front end: accepts requests, decodes the function and queues commands
// depends on tqsb_pkg and tqsb_fifo
`timescale 1ns / 1ps

module tqsb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  tqsb_pkg::req_type req_data,
   output logic              req_full,
   input  logic              cmd_pop,
   output tqsb_pkg::cmd_type cmd_data,
   output logic              cmd_empty
);

   tqsb_pkg::cmd_type cmd_dec;
   logic              cmd_known;
   logic              cmd_full;
   logic [$bits(tqsb_pkg::cmd_type)-1:0] cmd_vec;

   always_comb begin
      cmd_dec.queue_sel  = req_data.queue_sel;
      cmd_dec.item_value = req_data.item_value;
      cmd_dec.op         = tqsb_pkg::OP_ADD;
      cmd_known          = 1'b1;
      case (req_data.func)
         tqsb_pkg::FUNC_ADD:  cmd_dec.op = tqsb_pkg::OP_ADD;
         tqsb_pkg::FUNC_DEL:  cmd_dec.op = tqsb_pkg::OP_DEL;
         tqsb_pkg::FUNC_LIST: cmd_dec.op = tqsb_pkg::OP_LIST;
         default:             cmd_known  = 1'b0;
      endcase
   end

   // unknown function codes are taken and dropped
   assign req_full = cmd_full;

   tqsb_fifo #(
      .WIDTH ($bits(tqsb_pkg::cmd_type)),
      .DEPTH (tqsb_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push && cmd_known),
      .data_in  (cmd_dec),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .data_out (cmd_vec),
      .empty    (cmd_empty)
   );

   assign cmd_data = tqsb_pkg::cmd_type'(cmd_vec);

endmodule

FILE: rtl/core/tqsb_back.sv
// back end: owns the shared store and both queue pointers, runs commands
// depends on tqsb_pkg
`timescale 1ns / 1ps

module tqsb_back #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tqsb_pkg::cmd_type cmd_data,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output tqsb_pkg::rsp_type rsp_item,
   output logic              rsp_push,
   input  logic              rsp_full
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEL,
      S_LIST
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] low_head_ff, low_head_in;
   logic [PW-1:0] low_tail_ff, low_tail_in;
   logic [PW-1:0] high_head_ff, high_head_in;
   logic [PW-1:0] high_tail_ff, high_tail_in;
   logic [PW-1:0] walk_ff, walk_in;
   logic [tqsb_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic          wq_ff, wq_in;

   logic signed [tqsb_pkg::VALUE_W-1:0] store_ff [CAPACITY];
   logic signed [tqsb_pkg::VALUE_W-1:0] rd_data_ff;
   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic signed [tqsb_pkg::VALUE_W-1:0] wr_data;

   logic low_empty, high_empty, sel_empty, fin;
   logic [PW-1:0] walk_next;

   assign low_empty  = (low_tail_ff == '0) || (low_head_ff >= low_tail_ff);
   assign high_empty = (high_tail_ff >= PW'(CAPACITY)) || (high_head_ff >= PW'(CAPACITY))
                       || (high_head_ff < high_tail_ff);
   assign sel_empty  = cmd_data.queue_sel ? high_empty : low_empty;
   assign fin        = (wq_ff ? (walk_ff == high_tail_ff) : (walk_ff + PW'(1) == low_tail_ff))
                       || (cnt_ff == tqsb_pkg::COUNT_W'(tqsb_pkg::MAX_RESULTS - 1));
   assign walk_next  = wq_ff ? walk_ff - PW'(1) : walk_ff + PW'(1);

   always_comb begin
      state_in     = state_ff;
      low_head_in  = low_head_ff;
      low_tail_in  = low_tail_ff;
      high_head_in = high_head_ff;
      high_tail_in = high_tail_ff;
      walk_in      = walk_ff;
      cnt_in       = cnt_ff;
      wq_in        = wq_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_item     = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cmd_data.item_value;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop              = 1'b1;
               rsp_item.which_queue = cmd_data.queue_sel;
               rsp_item.last        = 1'b1;
               case (cmd_data.op)
                  tqsb_pkg::OP_ADD: begin
                     rsp_push = 1'b1;
                     if (low_tail_ff >= high_tail_ff) begin
                        rsp_item.status = tqsb_pkg::STAT_OVF;
                     end else if (!cmd_data.queue_sel) begin
                        rsp_item.status = tqsb_pkg::STAT_OK;
                        wr_en           = 1'b1;
                        wr_addr         = low_tail_ff[IW-1:0];
                        low_tail_in     = low_tail_ff + PW'(1);
                        if (low_tail_ff == '0) begin
                           low_head_in = '0;
                        end
                     end else begin
                        rsp_item.status = tqsb_pkg::STAT_OK;
                        wr_en           = 1'b1;
                        wr_addr         = IW'(high_tail_ff - PW'(1));
                        high_tail_in    = high_tail_ff - PW'(1);
                        if (high_tail_ff == PW'(CAPACITY)) begin
                           high_head_in = PW'(CAPACITY - 1);
                        end
                     end
                  end
                  tqsb_pkg::OP_DEL: begin
                     if (sel_empty) begin
                        rsp_push        = 1'b1;
                        rsp_item.status = tqsb_pkg::STAT_UNDER;
                     end else begin
                        rd_en    = 1'b1;
                        wq_in    = cmd_data.queue_sel;
                        state_in = S_DEL;
                        if (!cmd_data.queue_sel) begin
                           rd_addr = low_head_ff[IW-1:0];
                           if (low_head_ff + PW'(1) == low_tail_ff) begin
                              low_head_in = '0;
                              low_tail_in = '0;
                           end else begin
                              low_head_in = low_head_ff + PW'(1);
                           end
                        end else begin
                           rd_addr = high_head_ff[IW-1:0];
                           if (high_head_ff == high_tail_ff) begin
                              high_head_in = PW'(CAPACITY);
                              high_tail_in = PW'(CAPACITY);
                           end else begin
                              high_head_in = high_head_ff - PW'(1);
                           end
                        end
                     end
                  end
                  tqsb_pkg::OP_LIST: begin
                     if (sel_empty) begin
                        rsp_push        = 1'b1;
                        rsp_item.status = tqsb_pkg::STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        wq_in    = cmd_data.queue_sel;
                        cnt_in   = '0;
                        state_in = S_LIST;
                        walk_in  = cmd_data.queue_sel ? high_head_ff : low_head_ff;
                        rd_addr  = cmd_data.queue_sel ? high_head_ff[IW-1:0]
                                                      : low_head_ff[IW-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DEL: begin
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_item.value       = rd_data_ff;
               rsp_item.status      = tqsb_pkg::STAT_OK;
               rsp_item.which_queue = wq_ff;
               rsp_item.last        = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_LIST: begin
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_item.value       = rd_data_ff;
               rsp_item.status      = tqsb_pkg::STAT_OK;
               rsp_item.which_queue = wq_ff;
               rsp_item.last        = fin;
               if (fin) begin
                  state_in = S_IDLE;
               end else begin
                  walk_in = walk_next;
                  cnt_in  = cnt_ff + tqsb_pkg::COUNT_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = walk_next[IW-1:0];
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_head_ff  <= '0;
         low_tail_ff  <= '0;
         high_head_ff <= PW'(CAPACITY);
         high_tail_ff <= PW'(CAPACITY);
         walk_ff      <= '0;
         cnt_ff       <= '0;
         wq_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_head_ff  <= low_head_in;
         low_tail_ff  <= low_tail_in;
         high_head_ff <= high_head_in;
         high_tail_ff <= high_tail_in;
         walk_ff      <= walk_in;
         cnt_ff       <= cnt_in;
         wq_ff        <= wq_in;
      end
   end

   // shared store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

FILE: verif/two_queues_shared_buffer_tb.sv
// self-checking testbench for two_queues_shared_buffer
// a shadow of both queues predicts every response; depends on tqsb_pkg and the rtl
`timescale 1ns / 1ps

module two_queues_shared_buffer_tb;

   localparam int CAP = 16;
   localparam int RANDOM_REQS = 175;
   localparam int QUIET_FROM = 140;
   localparam int LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   class shared_buffer_shadow;
      logic [tqsb_pkg::VALUE_W-1:0] mem [CAP];
      int lo_head;
      int lo_tail;
      int hi_head;
      int hi_tail;
      tqsb_pkg::rsp_type awaited_rsp [$];
      int errors;

      function new();
         lo_head = 0;
         lo_tail = 0;
         hi_head = CAP;
         hi_tail = CAP;
         errors = 0;
      endfunction

      function bit is_empty(logic q);
         if (q == 1'b0)
            return (lo_tail == 0) || (lo_head >= lo_tail);
         return (hi_tail >= CAP) || (hi_head >= CAP) || (hi_head < hi_tail);
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      function void take_request(tqsb_pkg::req_type r);
         tqsb_pkg::rsp_type e;
         int n;
         int i;
         e.value = '0;
         e.status = tqsb_pkg::STAT_OK;
         e.which_queue = r.queue_sel;
         e.last = 1'b1;
         case (r.func)
            tqsb_pkg::FUNC_ADD: begin
               if (lo_tail >= hi_tail) begin
                  e.status = tqsb_pkg::STAT_OVF;
               end else if (r.queue_sel == 1'b0) begin
                  if (lo_tail == 0) lo_head = 0;
                  mem[lo_tail] = r.item_value;
                  lo_tail++;
               end else begin
                  if (hi_tail == CAP) hi_head = CAP - 1;
                  hi_tail--;
                  mem[hi_tail] = r.item_value;
               end
               awaited_rsp.push_back(e);
            end
            tqsb_pkg::FUNC_DEL: begin
               if (is_empty(r.queue_sel)) begin
                  e.status = tqsb_pkg::STAT_UNDER;
               end else if (r.queue_sel == 1'b0) begin
                  e.value = mem[lo_head];
                  if (lo_head + 1 == lo_tail) begin
                     lo_head = 0;
                     lo_tail = 0;
                  end else begin
                     lo_head++;
                  end
               end else begin
                  e.value = mem[hi_head];
                  if (hi_head == hi_tail) begin
                     hi_head = CAP;
                     hi_tail = CAP;
                  end else begin
                     hi_head--;
                  end
               end
               awaited_rsp.push_back(e);
            end
            tqsb_pkg::FUNC_LIST: begin
               if (is_empty(r.queue_sel)) begin
                  e.status = tqsb_pkg::STAT_EMPTY;
                  awaited_rsp.push_back(e);
               end else if (r.queue_sel == 1'b0) begin
                  n = 0;
                  for (i = lo_head; i < lo_tail && n < tqsb_pkg::MAX_RESULTS; i++) begin
                     e.value = mem[i];
                     e.last = (i + 1 == lo_tail) || (n + 1 == tqsb_pkg::MAX_RESULTS);
                     awaited_rsp.push_back(e);
                     n++;
                  end
               end else begin
                  n = 0;
                  i = hi_head;
                  do begin
                     e.value = mem[i];
                     e.last = (i == hi_tail) || (n + 1 == tqsb_pkg::MAX_RESULTS);
                     awaited_rsp.push_back(e);
                     n++;
                     i--;
                  end while (!e.last);
               end
            end
            default: ;
         endcase
      endfunction

      function void report(string field, logic [tqsb_pkg::VALUE_W-1:0] exp_v,
                           logic [tqsb_pkg::VALUE_W-1:0] act_v);
         errors++;
         $display("%0t: response %s mismatch, expected %0h, actual %0h",
                  $time, field, exp_v, act_v);
      endfunction

      function void match_response(tqsb_pkg::rsp_type a);
         tqsb_pkg::rsp_type e;
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, a);
            return;
         end
         e = awaited_rsp.pop_front();
         if (a.value !== e.value) report("value", e.value, a.value);
         if (a.status !== e.status) report("status", e.status, a.status);
         if (a.which_queue !== e.which_queue) report("which_queue", e.which_queue, a.which_queue);
         if (a.last !== e.last) report("last", e.last, a.last);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   tqsb_pkg::req_type req_data = '0;
   logic              req_full;
   logic              rsp_pop = 1'b0;
   tqsb_pkg::rsp_type rsp_data;
   logic              rsp_empty;

   shared_buffer_shadow shadow = new();
   bit quiet = 1'b0;
   int cycles = 0;

   two_queues_shared_buffer #(.CAPACITY(CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) shadow.match_response(rsp_data);
   end

   // receiver with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_pop <= 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic tqsb_pkg::req_type make_req(logic [1:0] f, logic q,
                                                  logic [tqsb_pkg::VALUE_W-1:0] v);
      tqsb_pkg::req_type r;
      r.func = f;
      r.queue_sel = q;
      r.item_value = v;
      return r;
   endfunction

   task automatic send(tqsb_pkg::req_type r);
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      shadow.take_request(r);
   endtask

   task automatic hold_off(int n);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 17));
   endtask

   task automatic directed_requests();
      int k;
      send(make_req(tqsb_pkg::FUNC_LIST, 1'b0, 32'h0));
      send(make_req(tqsb_pkg::FUNC_LIST, 1'b1, 32'hffff_ffff));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b0, 32'h0));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b1, 32'h0));
      send(make_req(FUNC_UNUSED, 1'b0, 32'h1234_5678));
      send(make_req(tqsb_pkg::FUNC_ADD, 1'b0, 32'h7fff_ffff));
      send(make_req(tqsb_pkg::FUNC_ADD, 1'b0, 32'h8000_0000));
      send(make_req(tqsb_pkg::FUNC_ADD, 1'b1, 32'h0));
      send(make_req(tqsb_pkg::FUNC_ADD, 1'b1, 32'hffff_ffff));
      send(make_req(tqsb_pkg::FUNC_LIST, 1'b0, 32'h0));
      send(make_req(tqsb_pkg::FUNC_LIST, 1'b1, 32'h0));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b0, 32'hffff_ffff));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b1, 32'h0));
      send(make_req(FUNC_UNUSED, 1'b1, 32'hffff_ffff));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b0, 32'h0));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b1, 32'h0));
      send(make_req(tqsb_pkg::FUNC_DEL, 1'b0, 32'h0));
      // fill the whole store from the bottom, then overflow and a full-length list
      for (k = 0; k < CAP; k++) send(make_req(tqsb_pkg::FUNC_ADD, 1'b0, $urandom));
      send(make_req(tqsb_pkg::FUNC_ADD, 1'b1, 32'h5555_5555));
      send(make_req(tqsb_pkg::FUNC_LIST, 1'b0, 32'h0));
   endtask

   function automatic tqsb_pkg::req_type random_req();
      int pick;
      logic [1:0] f;
      logic [tqsb_pkg::VALUE_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 45) f = tqsb_pkg::FUNC_ADD;
      else if (pick < 80) f = tqsb_pkg::FUNC_DEL;
      else if (pick < 95) f = tqsb_pkg::FUNC_LIST;
      else f = FUNC_UNUSED;
      case ($urandom_range(0, 7))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         2: v = 32'hffff_ffff;
         3: v = 32'h0;
         default: v = $urandom;
      endcase
      return make_req(f, 1'($urandom_range(0, 1)), v);
   endfunction

   initial begin
      int k;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_requests();

      for (k = 0; k < RANDOM_REQS; k++) begin
         if (k == QUIET_FROM) quiet = 1'b1;
         if (k == RANDOM_REQS / 2) begin
            // let every response come back before going on
            hold_off(1);
            while (shadow.pending() != 0) @(posedge clock);
         end
         maybe_gap();
         send(random_req());
      end
      hold_off(1);

      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/tqsb_pkg.sv
rtl/core/tqsb_fifo.sv
rtl/core/tqsb_front.sv
rtl/core/tqsb_back.sv
rtl/core/two_queues_shared_buffer.sv
verif/two_queues_shared_buffer_tb.sv
